### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands, clocked on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define QRS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent at the same edge
`define QRS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared types and constants of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_W     = 16;
	localparam int ROOT_W     = 32;
	localparam int SQRT_STEPS = 32;
	localparam int RAD_W      = 64;
	localparam int REM_W      = 36;
	localparam int DIV_STEPS  = 35;
	localparam int DVD_W      = 35;
	localparam int DSR_W      = 17;

	// solution kind
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ONE  = 2'd1;
	localparam logic [1:0] KIND_TWO  = 2'd2;
	localparam logic [1:0] KIND_LIN  = 2'd3;

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [COEF_W-1:0]  a;
		logic signed [COEF_W-1:0]  b;
		logic signed [COEF_W-1:0]  c;
	} sq_tag_t;

	typedef struct packed {
		logic [DVD_W-1:0] dvd;
		logic [DSR_W-1:0] dsr;
		logic [DSR_W-1:0] rem;
		logic [DVD_W-1:0] q;
		logic             neg;
	} div_lane_t;

endpackage

### rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x*x + b*x + c = 0 in Q16.16 from Q8.8 coefficients
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid / in_stall with coef_a, coef_b, coef_c per beat
//   output channel: out_valid / out_stall with root_count, first_root,
//   second_root, overflow; exactly one output beat per input beat, in order
//   pipeline: two product/discriminant stages, 32 square root cells, one
//   numerator stage, 35 divider cells, output register
//   throughput: one beat per cycle unless out_stall holds a waiting result;
//   every stage is a cell of a fixed chain that moves forward in the same
//   cycle as its neighbors
//   when out_stall holds a waiting result the whole chain freezes and
//   in_stall rises; it drops as soon as the output beat is taken
//   reset empties the chain; no results are pending after reset
//   two roots are ordered minus-sqrt branch first; saturated roots set
//   overflow
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadratic_root_solver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] coef_a,
	input  logic signed [15:0] coef_b,
	input  logic signed [15:0] coef_c,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         root_count,
	output logic signed [31:0] first_root,
	output logic signed [31:0] second_root,
	output logic               overflow
);

	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// stage 1: products
	logic                valid_s1;
	logic signed [15:0]  a_s1, b_s1, c_s1;
	logic signed [31:0]  bb_s1, ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_a;
			b_s1  <= coef_b;
			c_s1  <= coef_c;
			bb_s1 <= coef_b * coef_b;
			ac_s1 <= coef_a * coef_c;
		end
	end

	// stage 2: discriminant and classification
	logic signed [33:0] d;
	logic [1:0]         kind;
	logic               valid_s2;
	logic [63:0]        x_s2;
	qrs_pkg::sq_tag_t   tag_s2;

	always_comb begin
		d = {{2{bb_s1[31]}}, bb_s1} - ({{2{ac_s1[31]}}, ac_s1} <<< 2);
		if (a_s1 == 16'sd0) begin
			kind = (b_s1 != 16'sd0) ? qrs_pkg::KIND_LIN : qrs_pkg::KIND_NONE;
		end else if (d == 34'sd0) begin
			kind = qrs_pkg::KIND_ONE;
		end else if (!d[33]) begin
			kind = qrs_pkg::KIND_TWO;
		end else begin
			kind = qrs_pkg::KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2        <= (kind == qrs_pkg::KIND_TWO) ? {d, 30'd0} : 64'd0;
			tag_s2.kind <= kind;
			tag_s2.a    <= a_s1;
			tag_s2.b    <= b_s1;
			tag_s2.c    <= c_s1;
		end
	end

	// square root chain
	logic                           sq_valid [0:qrs_pkg::SQRT_STEPS];
	logic [qrs_pkg::RAD_W-1:0]      sq_x     [0:qrs_pkg::SQRT_STEPS];
	logic [qrs_pkg::REM_W-1:0]      sq_rem   [0:qrs_pkg::SQRT_STEPS];
	logic [qrs_pkg::ROOT_W-1:0]     sq_root  [0:qrs_pkg::SQRT_STEPS];
	qrs_pkg::sq_tag_t               sq_tag   [0:qrs_pkg::SQRT_STEPS];

	assign sq_valid[0] = valid_s2;
	assign sq_x[0]     = x_s2;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;
	assign sq_tag[0]   = tag_s2;

	for (genvar i = 0; i < qrs_pkg::SQRT_STEPS; i++) begin : g_sqrt
		qrs_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (sq_valid[i]),
			.x_i     (sq_x[i]),
			.rem_i   (sq_rem[i]),
			.root_i  (sq_root[i]),
			.tag_i   (sq_tag[i]),
			.valid_q (sq_valid[i+1]),
			.x_q     (sq_x[i+1]),
			.rem_q   (sq_rem[i+1]),
			.root_q  (sq_root[i+1]),
			.tag_q   (sq_tag[i+1])
		);
	end

	// stage 3: numerators, divisors and signs
	qrs_pkg::sq_tag_t   t3;
	logic signed [33:0] b_ext, c_ext, base, s_ext, n0, n1;
	logic signed [15:0] den;
	logic [33:0]        un0, un1;
	logic [15:0]        ud;
	logic               valid_s3;
	logic [1:0]         kind_s3;
	qrs_pkg::div_lane_t lane0_s3, lane1_s3;

	always_comb begin
		t3    = sq_tag[qrs_pkg::SQRT_STEPS];
		b_ext = {{18{t3.b[15]}}, t3.b};
		c_ext = {{18{t3.c[15]}}, t3.c};
		base  = 34'sd0 - (b_ext <<< 15);
		s_ext = {2'b00, sq_root[qrs_pkg::SQRT_STEPS]};
		if (t3.kind == qrs_pkg::KIND_LIN) begin
			n0  = 34'sd0 - (c_ext <<< 16);
			n1  = 34'sd0;
			den = t3.b;
		end else begin
			n0  = base - s_ext;
			n1  = base + s_ext;
			den = t3.a;
		end
		un0 = n0[33] ? 34'(34'sd0 - n0) : n0;
		un1 = n1[33] ? 34'(34'sd0 - n1) : n1;
		ud  = den[15] ? 16'(16'sd0 - den) : den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= sq_valid[qrs_pkg::SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3      <= t3.kind;
			// round to nearest: (2n + d) / 2d
			lane0_s3.dvd <= {un0, 1'b0} + {19'd0, ud};
			lane0_s3.dsr <= {ud, 1'b0};
			lane0_s3.rem <= '0;
			lane0_s3.q   <= '0;
			lane0_s3.neg <= n0[33] ^ den[15];
			lane1_s3.dvd <= {un1, 1'b0} + {19'd0, ud};
			lane1_s3.dsr <= {ud, 1'b0};
			lane1_s3.rem <= '0;
			lane1_s3.q   <= '0;
			lane1_s3.neg <= n1[33] ^ den[15];
		end
	end

	// divider chain
	logic               dv_valid [0:qrs_pkg::DIV_STEPS];
	logic [1:0]         dv_kind  [0:qrs_pkg::DIV_STEPS];
	qrs_pkg::div_lane_t dv_lane0 [0:qrs_pkg::DIV_STEPS];
	qrs_pkg::div_lane_t dv_lane1 [0:qrs_pkg::DIV_STEPS];

	assign dv_valid[0] = valid_s3;
	assign dv_kind[0]  = kind_s3;
	assign dv_lane0[0] = lane0_s3;
	assign dv_lane1[0] = lane1_s3;

	for (genvar j = 0; j < qrs_pkg::DIV_STEPS; j++) begin : g_div
		qrs_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (dv_valid[j]),
			.kind_i  (dv_kind[j]),
			.lane0_i (dv_lane0[j]),
			.lane1_i (dv_lane1[j]),
			.valid_q (dv_valid[j+1]),
			.kind_q  (dv_kind[j+1]),
			.lane0_q (dv_lane0[j+1]),
			.lane1_q (dv_lane1[j+1])
		);
	end

	// output stage: sign, saturation, selection
	qrs_pkg::div_lane_t f0, f1;
	logic [1:0]         fkind;
	logic [31:0]        r0, r1;
	logic               o0, o1;
	logic [34:0]        nq0, nq1;
	logic [1:0]         cnt;
	logic [31:0]        fr0, fr1;
	logic               fovf;

	always_comb begin
		f0    = dv_lane0[qrs_pkg::DIV_STEPS];
		f1    = dv_lane1[qrs_pkg::DIV_STEPS];
		fkind = dv_kind[qrs_pkg::DIV_STEPS];
		nq0   = 35'd0 - f0.q;
		nq1   = 35'd0 - f1.q;
		if (f0.neg) begin
			o0 = f0.q > 35'd2147483648;
			r0 = o0 ? 32'h8000_0000 : nq0[31:0];
		end else begin
			o0 = f0.q > 35'd2147483647;
			r0 = o0 ? 32'h7FFF_FFFF : f0.q[31:0];
		end
		if (f1.neg) begin
			o1 = f1.q > 35'd2147483648;
			r1 = o1 ? 32'h8000_0000 : nq1[31:0];
		end else begin
			o1 = f1.q > 35'd2147483647;
			r1 = o1 ? 32'h7FFF_FFFF : f1.q[31:0];
		end
		case (fkind)
			qrs_pkg::KIND_ONE, qrs_pkg::KIND_LIN: begin
				cnt  = 2'd1;
				fr0  = r0;
				fr1  = 32'd0;
				fovf = o0;
			end
			qrs_pkg::KIND_TWO: begin
				cnt  = 2'd2;
				fr0  = r0;
				fr1  = r1;
				fovf = o0 | o1;
			end
			default: begin
				cnt  = 2'd0;
				fr0  = 32'd0;
				fr1  = 32'd0;
				fovf = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_valid[qrs_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_count  <= cnt;
			first_root  <= fr0;
			second_root <= fr1;
			overflow    <= fovf;
		end
	end

	`QRS_ASSERT_ALWAYS(a_count_range, !out_valid || root_count != 2'd3, "root_count out of range")
	`QRS_ASSERT_IMPL(a_none_clean, out_valid && root_count == 2'd0, first_root == 32'sd0 && second_root == 32'sd0 && !overflow, "no-root result not cleared")
	`QRS_ASSERT_IMPL(a_one_second, out_valid && root_count == 2'd1, second_root == 32'sd0, "single root with nonzero second root")

endmodule

### rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// one root bit of the digit-by-digit integer square root
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_i,
	input  logic [qrs_pkg::RAD_W-1:0]     x_i,
	input  logic [qrs_pkg::REM_W-1:0]     rem_i,
	input  logic [qrs_pkg::ROOT_W-1:0]    root_i,
	input  qrs_pkg::sq_tag_t              tag_i,
	output logic                          valid_q,
	output logic [qrs_pkg::RAD_W-1:0]     x_q,
	output logic [qrs_pkg::REM_W-1:0]     rem_q,
	output logic [qrs_pkg::ROOT_W-1:0]    root_q,
	output qrs_pkg::sq_tag_t              tag_q
);

	logic [qrs_pkg::REM_W-1:0] r;
	logic [qrs_pkg::REM_W-1:0] trial;
	logic                      ge;

	always_comb begin
		r     = {rem_i[qrs_pkg::REM_W-3:0], x_i[qrs_pkg::RAD_W-1 -: 2]};
		trial = {2'b00, root_i, 2'b01};
		ge    = (r >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= {x_i[qrs_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= ge ? (r - trial) : r;
			root_q <= {root_i[qrs_pkg::ROOT_W-2:0], ge};
			tag_q  <= tag_i;
		end
	end

endmodule

### rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// one quotient bit of restoring division, two lanes side by side
// ----------------------------------------------------------------------------
module qrs_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_i,
	input  logic [1:0]           kind_i,
	input  qrs_pkg::div_lane_t   lane0_i,
	input  qrs_pkg::div_lane_t   lane1_i,
	output logic                 valid_q,
	output logic [1:0]           kind_q,
	output qrs_pkg::div_lane_t   lane0_q,
	output qrs_pkg::div_lane_t   lane1_q
);

	function automatic qrs_pkg::div_lane_t step(input qrs_pkg::div_lane_t l);
		qrs_pkg::div_lane_t      o;
		logic [qrs_pkg::DSR_W:0] r;
		logic                    ge;
		r  = {l.rem, l.dvd[qrs_pkg::DVD_W-1]};
		ge = (r >= {1'b0, l.dsr});
		o       = l;
		o.dvd   = {l.dvd[qrs_pkg::DVD_W-2:0], 1'b0};
		o.rem   = ge ? qrs_pkg::DSR_W'(r - {1'b0, l.dsr}) : r[qrs_pkg::DSR_W-1:0];
		o.q     = {l.q[qrs_pkg::DVD_W-2:0], ge};
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q  <= kind_i;
			lane0_q <= step(lane0_i);
			lane1_q <= step(lane1_i);
		end
	end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// quadratic root solver testbench
// streams coefficient sets through the solver under random gaps and stalls,
// predicts root count, roots and overflow, and compares every output beat
// ----------------------------------------------------------------------------
module testbench;

	localparam int LATENCY = 71;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1850;

	typedef struct packed {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] c;
	} coefs_t;

	typedef struct packed {
		logic [1:0]         count;
		logic signed [31:0] r0;
		logic signed [31:0] r1;
		logic               ovf;
	} roots_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] coef_a = '0;
	logic signed [15:0] coef_b = '0;
	logic signed [15:0] coef_c = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [1:0] root_count;
	logic signed [31:0] first_root;
	logic signed [31:0] second_root;
	logic overflow;

	coefs_t pending_coefs[$];
	roots_t expected_roots[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int two_root_cnt = 0;
	int ovf_cnt = 0;
	int idle_cycles = 0;
	int hold_off = 0;
	bit hold_done = 1'b0;

	quadratic_root_solver uut (.*);

	always #4 clk = ~clk;

	task automatic add_coefs(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c);
		pending_coefs.insert(pending_coefs.size(), {a, b, c});
	endtask

	// integer floor square root
	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// round half away from zero, then saturate to Q16.16
	function automatic logic [31:0] round_div_sat(input longint num, input longint den,
			inout logic ovf);
		bit neg;
		logic [63:0] un, ud, q;
		neg = (num < 0) != (den < 0);
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		q = (2 * un + ud) / (2 * ud);
		if (neg) begin
			if (q > 64'h8000_0000) begin
				ovf = 1'b1;
				return 32'h8000_0000;
			end
			return 32'(-q);
		end
		if (q > 64'h7FFF_FFFF) begin
			ovf = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return q[31:0];
	endfunction

	function automatic roots_t solve_roots(input coefs_t k);
		roots_t r;
		longint a, b, c, d, s, base;
		logic ovf;
		a = k.a;
		b = k.b;
		c = k.c;
		ovf = 1'b0;
		r = '0;
		if (a == 0) begin
			if (b != 0) begin
				r.r0 = round_div_sat(-c * 65536, b, ovf);
				r.count = 2'd1;
			end
		end else begin
			d = b * b - 4 * a * c;
			base = -b * 32768;
			if (d == 0) begin
				r.r0 = round_div_sat(base, a, ovf);
				r.count = 2'd1;
			end else if (d > 0) begin
				s = longint'(floor_sqrt(64'(d) << 30));
				r.r0 = round_div_sat(base - s, a, ovf);
				r.r1 = round_div_sat(base + s, a, ovf);
				r.count = 2'd2;
			end
		end
		r.ovf = ovf;
		return r;
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return '0;
			3: return 16'($signed($urandom_range(0, 16)) - 8);
			4: return 16'($signed($urandom_range(0, 2048)) - 1024);
			default: return 16'($urandom);
		endcase
	endfunction

	// driver
	int gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_roots.insert(expected_roots.size(),
					solve_roots({coef_a, coef_b, coef_c}));
				sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap > 0) begin
					gap <= gap - 1;
					in_valid <= 1'b0;
				end else if (pending_coefs.size() > 0) begin
					coefs_t k;
					k = pending_coefs.pop_front();
					{coef_a, coef_b, coef_c} <= k;
					in_valid <= 1'b1;
					gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall
	int stall_cnt = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				roots_t got, want;
				got = {root_count, first_root, second_root, overflow};
				received++;
				if (expected_roots.size() == 0) begin
					$error("output beat with no expected result");
					errors++;
				end else begin
					want = expected_roots.pop_front();
					if (got.count == 2'd2) two_root_cnt++;
					if (got.ovf) ovf_cnt++;
					if (got.count !== want.count) begin
						$error("root_count exp %0d got %0d", want.count, got.count);
						errors++;
					end
					if (got.r0 !== want.r0) begin
						$error("first_root exp %0d got %0d", want.r0, got.r0);
						errors++;
					end
					if (got.r1 !== want.r1) begin
						$error("second_root exp %0d got %0d", want.r1, got.r1);
						errors++;
					end
					if (got.ovf !== want.ovf) begin
						$error("overflow exp %0d got %0d", want.ovf, got.ovf);
						errors++;
					end
				end
			end
			// one long hold-off once traffic is flowing, so the chain fills
			if (!hold_done && sent > 300) begin
				hold_done <= 1'b1;
				hold_off <= 400;
				out_stall <= 1'b1;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_stall <= 1'b1;
			end else if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall && $urandom_range(0, 3) == 0) begin
				stall_cnt <= $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding",
					expected_roots.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		coefs_t k;
		int p, q;
		// directed: extremes, linear, no-root, double-root and two-root cases
		add_coefs(16'sh0000, 16'sh0000, 16'sh0000);
		add_coefs(16'sh0000, 16'sh0000, 16'sh0100);
		add_coefs(16'sh0000, 16'sh0100, 16'sh0200);
		add_coefs(16'sh0000, 16'sh0001, 16'sh7FFF);
		add_coefs(16'sh0000, 16'sh0001, 16'sh8000);
		add_coefs(16'sh0000, 16'sh8000, 16'sh8000);
		add_coefs(16'sh0000, 16'sh0003, 16'sh0001);
		add_coefs(16'sh0100, 16'sh0000, 16'sh0100);
		add_coefs(16'sh0100, 16'shFE00, 16'sh0100);
		add_coefs(16'sh0001, 16'sh0002, 16'sh0001);
		add_coefs(16'sh0100, 16'sh0000, 16'shFF00);
		add_coefs(16'shFF00, 16'sh0100, 16'sh0200);
		add_coefs(16'sh0001, 16'sh7FFF, 16'sh0000);
		add_coefs(16'sh0001, 16'sh8000, 16'sh8000);
		add_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		add_coefs(16'sh8000, 16'sh8000, 16'sh8000);
		add_coefs(16'sh8000, 16'sh7FFF, 16'sh7FFF);
		add_coefs(16'shFFFF, 16'sh8000, 16'sh7FFF);
		add_coefs(16'sh7FFF, 16'sh0000, 16'sh8000);
		add_coefs(16'sh0001, 16'sh0000, 16'sh8000);
		add_coefs(16'sh0001, 16'sh0001, 16'sh0000);
		add_coefs(16'sh0000, 16'shFFFF, 16'sh0001);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			k.a = ($urandom_range(0, 7) == 0) ? 16'sh0 : rand_coef();
			k.b = rand_coef();
			k.c = rand_coef();
			// a = p*p, b = 2pq, c = q*q gives b*b == 4ac, a double root
			if ($urandom_range(0, 9) == 0) begin
				p = $urandom_range(1, 16);
				q = int'($urandom_range(0, 32)) - 16;
				k.a = 16'(p * p);
				k.b = 16'(2 * p * q);
				k.c = 16'(q * q);
			end
			pending_coefs.insert(pending_coefs.size(), k);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_coefs.size() == 0 && !in_valid);
		wait (expected_roots.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("sent %0d coefficient sets, checked %0d results", sent, received);
		$display("%0d two-root results, %0d saturated", two_root_cnt, ovf_cnt);
		if (errors == 0 && expected_roots.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
tb/testbench.sv
